FILE: rtl/md5sh_pkg.sv
package md5sh_pkg;

   // One 32-bit message word on its way from the front end to the round engine.
   // msg_end marks word 15 of the last block of a message.
   typedef struct packed {
      logic [31:0] word;
      logic        msg_end;
   } qword_type;

   localparam logic [3:0][31:0] INIT_VECTOR = {
      32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [31:0] STEP_CONST [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Indexed by {round group, step within the group mod 4}.
   localparam logic [4:0] ROT_AMOUNT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // Message word used by step i.
   function automatic logic [3:0] msg_index(input logic [5:0] i);
      logic [3:0] lo;
      logic [3:0] g;
      lo = i[3:0];
      unique case (i[5:4])
         2'd0: g = lo;
         2'd1: g = lo * 4'd5 + 4'd1;
         2'd2: g = lo * 4'd3 + 4'd5;
         2'd3: g = lo * 4'd7;
      endcase
      return g;
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
      logic [63:0] dbl;
      dbl = {v, v} << s;
      return dbl[63:32];
   endfunction

endpackage

FILE: rtl/md5sh_front.sv
module md5sh_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   output logic                  push,
   output md5sh_pkg::qword_type  push_data,
   input  logic                  q_full
);

   localparam logic ST_BYTES = 1'b0;
   localparam logic ST_PAD   = 1'b1;

   logic        state_ff, state_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [31:0] acc_ff, acc_in;
   logic [3:0]  wi_ff, wi_in;
   logic        len_blk_ff, len_blk_in;

   logic [1:0]  lane;
   logic [31:0] byte_word;
   logic [3:0]  start_idx;
   logic        accept;

   assign lane       = cnt_ff[1:0];
   assign byte_word  = acc_ff | ({24'd0, req_tdata} << {lane, 3'b000});
   assign req_tready = (state_ff == ST_BYTES) && !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      acc_in     = acc_ff;
      wi_in      = wi_ff;
      len_blk_in = len_blk_ff;
      push       = 1'b0;
      push_data  = '{word: byte_word, msg_end: 1'b0};
      start_idx  = cnt_ff[5:2];

      if (state_ff == ST_BYTES) begin
         if (accept) begin
            cnt_in = cnt_ff + 32'd1;
            if (lane == 2'd3) begin
               // word complete; on the last byte the pad byte opens the next word
               push      = 1'b1;
               start_idx = cnt_ff[5:2] + 4'd1;
               acc_in    = req_tlast ? {24'd0, md5sh_pkg::PAD_BYTE} : 32'd0;
            end else begin
               start_idx = cnt_ff[5:2];
               acc_in    = req_tlast
                         ? byte_word | ({24'd0, md5sh_pkg::PAD_BYTE}
                                        << {2'(lane + 2'd1), 3'b000})
                         : byte_word;
            end
            if (req_tlast) begin
               state_in   = ST_PAD;
               wi_in      = start_idx;
               len_blk_in = (start_idx < 4'd14);
            end
         end
      end else begin
         if (!q_full) begin
            push = 1'b1;
            if (len_blk_ff && wi_ff == 4'd14) begin
               push_data.word = {cnt_ff[28:0], 3'b000};
            end else if (len_blk_ff && wi_ff == 4'd15) begin
               push_data.word = {29'd0, cnt_ff[31:29]};
            end else begin
               push_data.word = acc_ff;
            end
            push_data.msg_end = len_blk_ff && (wi_ff == 4'd15);
            acc_in = 32'd0;
            wi_in  = wi_ff + 4'd1;
            if (wi_ff == 4'd15) begin
               if (len_blk_ff) begin
                  state_in = ST_BYTES;
                  cnt_in   = 32'd0;
               end else begin
                  len_blk_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_BYTES;
         cnt_ff     <= 32'd0;
         acc_ff     <= 32'd0;
         wi_ff      <= 4'd0;
         len_blk_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         acc_ff     <= acc_in;
         wi_ff      <= wi_in;
         len_blk_ff <= len_blk_in;
      end
   end

endmodule

FILE: rtl/md5sh_queue.sv
module md5sh_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  md5sh_pkg::qword_type  push_data,
   output logic                  full,
   input  logic                  pop,
   output md5sh_pkg::qword_type  pop_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   md5sh_pkg::qword_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push && !full) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop && !empty) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if ((push && !full) && !(pop && !empty)) begin
            count_ff <= count_ff + 1'b1;
         end else if (!(push && !full) && (pop && !empty)) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: rtl/md5sh_core.sv
module md5sh_core (
   input  logic                  clock,
   input  logic                  reset,
   output logic                  pop,
   input  md5sh_pkg::qword_type  pop_data,
   input  logic                  q_empty,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,
   output logic                  rsp_tlast
);

   localparam logic [1:0] ST_LOAD = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_ADD  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [3:0]       wcnt_ff, wcnt_in;
   logic             msg_end_ff, msg_end_in;
   logic [5:0]       rnd_ff, rnd_in;
   logic [31:0]      a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [31:0]      kw_ff, kw_in;
   logic [3:0][31:0] chain_ff, chain_in;
   logic [1:0]       out_idx_ff, out_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_word_ff, rsp_word_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [31:0]      blk_ff [16];

   logic [31:0]      f_val;
   logic [31:0]      sum;
   logic [31:0]      b_new;
   logic [5:0]       rnd_next;

   assign pop        = (state_ff == ST_LOAD) && !q_empty;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rnd_next   = rnd_ff + 6'd1;

   // one MD5 step; kw_ff already holds constant plus message word
   always_comb begin
      unique case (rnd_ff[5:4])
         2'd0: f_val = d_ff ^ (b_ff & (c_ff ^ d_ff));
         2'd1: f_val = c_ff ^ (d_ff & (b_ff ^ c_ff));
         2'd2: f_val = b_ff ^ c_ff ^ d_ff;
         2'd3: f_val = c_ff ^ (b_ff | ~d_ff);
      endcase
      sum   = a_ff + f_val + kw_ff;
      b_new = b_ff + md5sh_pkg::rotl32(sum, md5sh_pkg::ROT_AMOUNT[{rnd_ff[5:4], rnd_ff[1:0]}]);
   end

   always_comb begin
      state_in     = state_ff;
      wcnt_in      = wcnt_ff;
      msg_end_in   = msg_end_ff;
      rnd_in       = rnd_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      kw_in        = kw_ff;
      chain_in     = chain_ff;
      out_idx_in   = out_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (pop) begin
               wcnt_in = wcnt_ff + 4'd1;
               if (wcnt_ff == 4'd15) begin
                  msg_end_in = pop_data.msg_end;
                  state_in   = ST_RUN;
                  rnd_in     = 6'd0;
                  a_in       = chain_ff[0];
                  b_in       = chain_ff[1];
                  c_in       = chain_ff[2];
                  d_in       = chain_ff[3];
                  kw_in      = md5sh_pkg::STEP_CONST[0] + blk_ff[0];
               end
            end
         end
         ST_RUN: begin
            a_in   = d_ff;
            b_in   = b_new;
            c_in   = b_ff;
            d_in   = c_ff;
            kw_in  = md5sh_pkg::STEP_CONST[rnd_next]
                   + blk_ff[md5sh_pkg::msg_index(rnd_next)];
            rnd_in = rnd_next;
            if (rnd_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            out_idx_in  = 2'd0;
            state_in    = msg_end_ff ? ST_OUT : ST_LOAD;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = chain_ff[out_idx_ff];
               rsp_last_in  = (out_idx_ff == 2'd3);
               out_idx_in   = out_idx_ff + 2'd1;
               if (out_idx_ff == 2'd3) begin
                  chain_in = md5sh_pkg::INIT_VECTOR;
                  state_in = ST_LOAD;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         blk_ff[wcnt_ff] <= pop_data.word;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      d_ff        <= d_in;
      kw_ff       <= kw_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
      msg_end_ff  <= msg_end_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         wcnt_ff      <= 4'd0;
         rnd_ff       <= 6'd0;
         chain_ff     <= md5sh_pkg::INIT_VECTOR;
         out_idx_ff   <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wcnt_ff      <= wcnt_in;
         rnd_ff       <= rnd_in;
         chain_ff     <= chain_in;
         out_idx_ff   <= out_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/md5_stream_hasher.sv
// MD5 stream hasher. Message bytes come in one per request on the req_ channel,
// req_tlast set on the final byte (a message holds at least one byte); the MD5
// digest goes out on the rsp_ channel as four 32-bit chaining words, word 0
// first, rsp_tlast set on the fourth. Each word is the raw chaining value: the
// usual hex text lists its bytes least significant first. After the digest the
// engine is back at the initial vector, ready for the next message; bytes of
// the next message may already be taken while the digest drains. The front end
// packs bytes into little-endian words and takes one byte per cycle while the
// word queue has room. After the last byte it generates the padding and length
// words itself, one word per cycle while the queue has room: 3 to 16 words, or
// 17 or 18 when the length spills into an extra block. No request is taken
// during that time. The round engine pulls 16 words from the queue, runs the
// 64 MD5 steps one per cycle and adds into the chaining words. While it runs,
// the front end gets at most QUEUE_DEPTH words ahead (4 by default) and then
// stalls, so most of the next block arrives during the load at one word per
// four bytes. Each block passes through load, steps and add in that order, and
// after the last block the digest leaves through the output register.

module md5_stream_hasher #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // request channel: message bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   // response channel: digest words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic        rsp_tlast    // digest_last
);

   md5sh_pkg::qword_type push_data;
   md5sh_pkg::qword_type pop_data;
   logic                 push;
   logic                 pop;
   logic                 q_full;
   logic                 q_empty;

   // byte packing, padding and length insertion
   md5sh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push       (push),
      .push_data  (push_data),
      .q_full     (q_full)
   );

   // word queue decoupling the byte side from the round engine
   md5sh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   // block load, 64 rounds, chaining add, digest output
   md5sh_core u_core (
      .clock      (clock),
      .reset      (reset),
      .pop        (pop),
      .pop_data   (pop_data),
      .q_empty    (q_empty),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
